// ===== hdl/ebs_pkg.sv =====
// ---------------------------------------------------------------------------
// ebs_pkg
// Shared types, codes and constants of the elevator boarding sequencer.
// ---------------------------------------------------------------------------
package ebs_pkg;

  localparam int COORD_BITS       = 16;
  localparam int CFG_WIDE_BITS    = 14;
  localparam int CFG_TICK_BITS    = 8;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int ABS_BITS         = COORD_BITS;
  localparam int CMP_BITS         = (ABS_BITS > CFG_WIDE_BITS) ? ABS_BITS : CFG_WIDE_BITS;
  localparam int FLOOR_CMP_BITS   = ((COORD_BITS + 1 > CFG_WIDE_BITS + 3) ?
                                     COORD_BITS + 1 : CFG_WIDE_BITS + 3) + 1;
  localparam int SQ_BITS          = 2 * CFG_WIDE_BITS;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [CMP_BITS-1:0] INSIDE_HEIGHT_MM = CMP_BITS'(1000);

  localparam logic [CFG_WIDE_BITS-1:0] LEVEL_HEIGHT_RST    = CFG_WIDE_BITS'(3075);
  localparam logic [CFG_WIDE_BITS-1:0] INSIDE_HALF_RST     = CFG_WIDE_BITS'(1125);
  localparam logic [CFG_WIDE_BITS-1:0] APPROACH_RADIUS_RST = CFG_WIDE_BITS'(2000);
  localparam logic [CFG_WIDE_BITS-1:0] SPEED_THRESHOLD_RST = CFG_WIDE_BITS'(50);
  localparam logic [CFG_TICK_BITS-1:0] DOOR_TICKS_RST      = CFG_TICK_BITS'(20);
  localparam logic [CFG_TICK_BITS-1:0] BOARDING_TICKS_RST  = CFG_TICK_BITS'(50);
  localparam logic [CFG_TICK_BITS-1:0] RETURN_TICKS_RST    = CFG_TICK_BITS'(30);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEVEL_HEIGHT    = 3'd0,
    REG_INSIDE_HALF     = 3'd1,
    REG_APPROACH_RADIUS = 3'd2,
    REG_SPEED_THRESHOLD = 3'd3,
    REG_DOOR_TICKS      = 3'd4,
    REG_BOARDING_TICKS  = 3'd5,
    REG_RETURN_TICKS    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FLOOR_LOWER   = 2'd0,
    FLOOR_UPPER   = 2'd1,
    FLOOR_BETWEEN = 2'd2
  } floor_t;

  typedef enum logic [1:0] {
    DOOR_CLOSED     = 2'd0,
    DOOR_GOING_OPEN = 2'd1,
    DOOR_OPENED     = 2'd2,
    DOOR_GOING_SHUT = 2'd3
  } door_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_OPENING  = 3'd1,
    PH_BOARDING = 3'd2,
    PH_CLOSING  = 3'd3,
    PH_TRAVEL   = 3'd4,
    PH_ARRIVED  = 3'd5
  } phase_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] car_x;
    logic signed [COORD_BITS-1:0] car_y;
    logic signed [COORD_BITS-1:0] car_z;
    logic signed [COORD_BITS-1:0] car_speed_z;
    logic signed [COORD_BITS-1:0] robot_x;
    logic signed [COORD_BITS-1:0] robot_y;
    logic signed [COORD_BITS-1:0] robot_z;
  } ebs_in_t;

  typedef struct packed {
    logic [1:0] floor_code;
    logic [1:0] door_status;
    logic       car_moving;
    logic       robot_in_car;
    logic [2:0] sequence_phase;
    logic       floor_command_valid;
    logic       floor_command_target;
  } ebs_out_t;

  typedef struct packed {
    floor_t floor_code;
    logic   moving;
    logic   in_car;
    logic   near;
  } ebs_class_t;

  typedef struct packed {
    logic [CFG_WIDE_BITS-1:0] level_height;
    logic [CFG_WIDE_BITS-1:0] inside_half;
    logic [CFG_WIDE_BITS-1:0] approach_radius;
    logic [CFG_WIDE_BITS-1:0] speed_threshold;
  } ebs_cfg_front_t;

  typedef struct packed {
    logic [CFG_TICK_BITS-1:0] door_ticks;
    logic [CFG_TICK_BITS-1:0] boarding_ticks;
    logic [CFG_TICK_BITS-1:0] return_ticks;
  } ebs_cfg_back_t;

  function automatic logic [CFG_TICK_BITS-1:0] ticks(input logic [CFG_TICK_BITS-1:0] t);
    return (t == '0) ? CFG_TICK_BITS'(1) : t;
  endfunction

endpackage

// ===== hdl/elevator_boarding_sequencer.sv =====
// ---------------------------------------------------------------------------
// elevator_boarding_sequencer
// Path: classifier stages, tick queue, then the sequencer and result register.
// Throughput: one word per cycle while no queue or result stall holds the flow.
// Reset (synchronous): registers to defaults, buffers empty, phase idle,
// door closed, both timers stopped.
// Classifier front, tick queue and sequencer back run decoupled.
// ---------------------------------------------------------------------------
module elevator_boarding_sequencer #(
  parameter int QUEUE_DEPTH = ebs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  ebs_pkg::ebs_in_t                     item,
  output logic                                 empty,
  input  logic                                 pop,
  output ebs_pkg::ebs_out_t                    result,
  input  logic                                 wr_en,
  input  logic [ebs_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  logic [ebs_pkg::CFG_WIDE_BITS-1:0]    wr_data
);
  import ebs_pkg::*;

  ebs_cfg_front_t cfg_front;
  ebs_cfg_back_t  cfg_back;
  logic           q_push, q_full, q_pop, q_empty;
  ebs_class_t     q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_front.level_height    <= LEVEL_HEIGHT_RST;
      cfg_front.inside_half     <= INSIDE_HALF_RST;
      cfg_front.approach_radius <= APPROACH_RADIUS_RST;
      cfg_front.speed_threshold <= SPEED_THRESHOLD_RST;
      cfg_back.door_ticks       <= DOOR_TICKS_RST;
      cfg_back.boarding_ticks   <= BOARDING_TICKS_RST;
      cfg_back.return_ticks     <= RETURN_TICKS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEVEL_HEIGHT:    cfg_front.level_height    <= wr_data;
        REG_INSIDE_HALF:     cfg_front.inside_half     <= wr_data;
        REG_APPROACH_RADIUS: cfg_front.approach_radius <= wr_data;
        REG_SPEED_THRESHOLD: cfg_front.speed_threshold <= wr_data;
        REG_DOOR_TICKS:      cfg_back.door_ticks       <= wr_data[CFG_TICK_BITS-1:0];
        REG_BOARDING_TICKS:  cfg_back.boarding_ticks   <= wr_data[CFG_TICK_BITS-1:0];
        REG_RETURN_TICKS:    cfg_back.return_ticks     <= wr_data[CFG_TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  ebs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_front),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  ebs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ebs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_back),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cls     (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== hdl/ebs_front.sv =====
// ---------------------------------------------------------------------------
// ebs_front
// Three-stage classifier: floor, motion, inside-car and approach test.
// ---------------------------------------------------------------------------
module ebs_front (
  input  logic                    clk,
  input  logic                    rst,
  input  ebs_pkg::ebs_cfg_front_t cfg,
  input  logic                    push,
  output logic                    full,
  input  ebs_pkg::ebs_in_t        item,
  output logic                    q_push,
  input  logic                    q_full,
  output ebs_pkg::ebs_class_t     q_data
);
  import ebs_pkg::*;

  logic advance;

  logic signed [COORD_BITS:0]     dx, dy, dz, vz;
  logic [COORD_BITS:0]            ndx, ndy, ndz, nvz;
  logic [CMP_BITS-1:0]            adx, ady, adz, avz;
  logic [CMP_BITS-1:0]            half, rad, thr;
  logic signed [FLOOR_CMP_BITS-1:0] cz2, h1, h3;
  floor_t                         floor_s0;
  logic                           in_car_s0;

  logic                           v1;
  floor_t                         floor1;
  logic                           moving1, in_car1, pre1;
  logic [CFG_WIDE_BITS-1:0]       ax1, ay1, rad1;

  logic                           v2;
  floor_t                         floor2;
  logic                           moving2, in_car2, pre2;
  logic [SQ_BITS-1:0]             sqx2, sqy2, rsq2;

  logic                           v3;
  ebs_class_t                     cls3;

  assign advance = !(v3 && q_full);
  assign full    = !advance;
  assign q_push  = v3 && !q_full;
  assign q_data  = cls3;

  always_comb begin
    dx  = {item.robot_x[COORD_BITS-1], item.robot_x} - {item.car_x[COORD_BITS-1], item.car_x};
    dy  = {item.robot_y[COORD_BITS-1], item.robot_y} - {item.car_y[COORD_BITS-1], item.car_y};
    dz  = {item.robot_z[COORD_BITS-1], item.robot_z} - {item.car_z[COORD_BITS-1], item.car_z};
    vz  = {item.car_speed_z[COORD_BITS-1], item.car_speed_z};
    ndx = -dx;
    ndy = -dy;
    ndz = -dz;
    nvz = -vz;
    adx = CMP_BITS'(dx[COORD_BITS] ? ndx[ABS_BITS-1:0] : dx[ABS_BITS-1:0]);
    ady = CMP_BITS'(dy[COORD_BITS] ? ndy[ABS_BITS-1:0] : dy[ABS_BITS-1:0]);
    adz = CMP_BITS'(dz[COORD_BITS] ? ndz[ABS_BITS-1:0] : dz[ABS_BITS-1:0]);
    avz = CMP_BITS'(vz[COORD_BITS] ? nvz[ABS_BITS-1:0] : vz[ABS_BITS-1:0]);
    half = CMP_BITS'(cfg.inside_half);
    rad  = CMP_BITS'(cfg.approach_radius);
    thr  = CMP_BITS'(cfg.speed_threshold);

    cz2 = FLOOR_CMP_BITS'($signed({item.car_z, 1'b0}));
    h1  = $signed({{(FLOOR_CMP_BITS-CFG_WIDE_BITS){1'b0}}, cfg.level_height});
    h3  = h1 + (h1 <<< 1);
    if (cz2 < h1) begin
      floor_s0 = FLOOR_LOWER;
    end else if (cz2 > h3) begin
      floor_s0 = FLOOR_UPPER;
    end else begin
      floor_s0 = FLOOR_BETWEEN;
    end
    in_car_s0 = (adx < half) && (ady < half) && (adz < INSIDE_HEIGHT_MM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      floor1  <= floor_s0;
      moving1 <= avz > thr;
      in_car1 <= in_car_s0;
      pre1    <= (floor_s0 == FLOOR_LOWER) && !in_car_s0 && (adx < rad) && (ady < rad);
      ax1     <= adx[CFG_WIDE_BITS-1:0];
      ay1     <= ady[CFG_WIDE_BITS-1:0];
      rad1    <= cfg.approach_radius;

      floor2  <= floor1;
      moving2 <= moving1;
      in_car2 <= in_car1;
      pre2    <= pre1;
      sqx2    <= ax1 * ax1;
      sqy2    <= ay1 * ay1;
      rsq2    <= rad1 * rad1;

      cls3.floor_code <= floor2;
      cls3.moving     <= moving2;
      cls3.in_car     <= in_car2;
      cls3.near       <= pre2 && (({1'b0, sqx2} + {1'b0, sqy2}) < {1'b0, rsq2});
    end
  end

endmodule

// ===== hdl/ebs_queue.sv =====
// ---------------------------------------------------------------------------
// ebs_queue
// Small first-in first-out buffer of classified ticks.
// ---------------------------------------------------------------------------
module ebs_queue #(
  parameter int DEPTH = ebs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ebs_pkg::ebs_class_t wdata,
  input  logic                pop,
  output logic                empty,
  output ebs_pkg::ebs_class_t rdata
);
  import ebs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ebs_class_t        mem [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/ebs_back.sv =====
// ---------------------------------------------------------------------------
// ebs_back
// Door timer, boarding/return timer and boarding sequencer with result register.
// ---------------------------------------------------------------------------
module ebs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ebs_pkg::ebs_cfg_back_t cfg,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  ebs_pkg::ebs_class_t    cls,
  output logic                   empty,
  input  logic                   pop,
  output ebs_pkg::ebs_out_t      result
);
  import ebs_pkg::*;

  phase_t                   phase, phase_next;
  door_t                    door, door_next;
  logic [CFG_TICK_BITS-1:0] door_cnt, door_cnt_next;
  logic [CFG_TICK_BITS-1:0] seq_cnt, seq_cnt_next;
  logic                     seq_run, seq_run_next;
  logic                     cmd;
  logic                     out_valid;
  logic                     advance;

  assign advance = !q_empty && (!out_valid || pop);
  assign q_pop   = advance;
  assign empty   = !out_valid;

  always_comb begin
    phase_next    = phase;
    door_next     = door;
    door_cnt_next = door_cnt;
    seq_cnt_next  = seq_cnt;
    seq_run_next  = seq_run;
    cmd           = 1'b0;

    if (door_cnt != '0) begin
      door_cnt_next = door_cnt - CFG_TICK_BITS'(1);
      if (door_cnt_next == '0) begin
        if (door == DOOR_GOING_OPEN) begin
          door_next = DOOR_OPENED;
        end else if (door == DOOR_GOING_SHUT) begin
          door_next = DOOR_CLOSED;
        end
      end
    end

    if (seq_run) begin
      if (seq_cnt > CFG_TICK_BITS'(1)) begin
        seq_cnt_next = seq_cnt - CFG_TICK_BITS'(1);
      end else begin
        seq_cnt_next = '0;
        seq_run_next = 1'b0;
        if (phase == PH_BOARDING) begin
          door_next     = DOOR_GOING_SHUT;
          door_cnt_next = ticks(cfg.door_ticks);
          phase_next    = PH_CLOSING;
        end else if (phase == PH_ARRIVED) begin
          phase_next = PH_IDLE;
        end
      end
    end

    unique case (phase_next)
      PH_IDLE: begin
        if (cls.near && cls.floor_code == FLOOR_LOWER) begin
          door_next     = DOOR_GOING_OPEN;
          door_cnt_next = ticks(cfg.door_ticks);
          phase_next    = PH_OPENING;
        end
      end
      PH_OPENING: begin
        if (door_next == DOOR_OPENED) begin
          phase_next   = PH_BOARDING;
          seq_cnt_next = ticks(cfg.boarding_ticks);
          seq_run_next = 1'b1;
        end
      end
      PH_BOARDING: begin
        if (cls.in_car) begin
          door_next     = DOOR_GOING_SHUT;
          door_cnt_next = ticks(cfg.door_ticks);
          phase_next    = PH_CLOSING;
          seq_run_next  = 1'b0;
          seq_cnt_next  = '0;
        end
      end
      PH_CLOSING: begin
        if (door_next == DOOR_CLOSED) begin
          cmd        = 1'b1;
          phase_next = PH_TRAVEL;
        end
      end
      PH_TRAVEL: begin
        if (!cls.moving && cls.floor_code == FLOOR_UPPER) begin
          door_next     = DOOR_GOING_OPEN;
          door_cnt_next = ticks(cfg.door_ticks);
          phase_next    = PH_ARRIVED;
        end
      end
      PH_ARRIVED: begin
        if (!cls.in_car && door_next == DOOR_OPENED) begin
          door_next     = DOOR_GOING_SHUT;
          door_cnt_next = ticks(cfg.door_ticks);
          seq_cnt_next  = ticks(cfg.return_ticks);
          seq_run_next  = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      door      <= DOOR_CLOSED;
      door_cnt  <= '0;
      seq_cnt   <= '0;
      seq_run   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      door      <= door_next;
      door_cnt  <= door_cnt_next;
      seq_cnt   <= seq_cnt_next;
      seq_run   <= seq_run_next;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.floor_code           <= cls.floor_code;
      result.door_status          <= door_next;
      result.car_moving           <= cls.moving;
      result.robot_in_car         <= cls.in_car;
      result.sequence_phase       <= phase_next;
      result.floor_command_valid  <= cmd;
      result.floor_command_target <= cmd;
    end
  end

endmodule

// ===== tb/sv/elevator_boarding_sequencer_tb.sv =====
// ---------------------------------------------------------------------------
// elevator_boarding_sequencer_tb
// Drives tick words through the sequencer and checks every result word
// against an in-bench prediction of the floor, door, occupancy and boarding
// sequence. Stimulus follows the predicted phase so that full boarding and
// arrival sequences occur, mixed with random and corner-value words, under
// several register settings. The sender works in bursts and the receiver
// stalls on its own pattern.
// ---------------------------------------------------------------------------
module elevator_boarding_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_SETTINGS   = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));

  typedef enum {ROBOT_ABOARD, ROBOT_NEAR, ROBOT_AWAY} robot_spot_t;
  typedef enum {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  ebs_in_t                   item;
  logic                      empty;
  logic                      pop;
  ebs_out_t                  result;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_WIDE_BITS-1:0]  wr_data;
  int                        cycles;

  elevator_boarding_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  class ebs_scoreboard;
    logic [CFG_WIDE_BITS-1:0] floor_h, half_w, radius, speed_thr;
    logic [CFG_TICK_BITS-1:0] door_ticks, board_ticks, return_ticks;
    phase_t                   ph;
    door_t                    door_pos;
    logic [CFG_TICK_BITS-1:0] door_cnt, seq_cnt;
    bit                       seq_run;
    ebs_out_t                 due[$];
    int                       errors;

    function new();
      floor_h      = LEVEL_HEIGHT_RST;
      half_w       = INSIDE_HALF_RST;
      radius       = APPROACH_RADIUS_RST;
      speed_thr    = SPEED_THRESHOLD_RST;
      door_ticks   = DOOR_TICKS_RST;
      board_ticks  = BOARDING_TICKS_RST;
      return_ticks = RETURN_TICKS_RST;
      ph           = PH_IDLE;
      door_pos     = DOOR_CLOSED;
      door_cnt     = '0;
      seq_cnt      = '0;
      seq_run      = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                          input logic [CFG_WIDE_BITS-1:0] d);
      case (idx)
        REG_LEVEL_HEIGHT:    floor_h = d;
        REG_INSIDE_HALF:     half_w = d;
        REG_APPROACH_RADIUS: radius = d;
        REG_SPEED_THRESHOLD: speed_thr = d;
        REG_DOOR_TICKS:      door_ticks = d[CFG_TICK_BITS-1:0];
        REG_BOARDING_TICKS:  board_ticks = d[CFG_TICK_BITS-1:0];
        REG_RETURN_TICKS:    return_ticks = d[CFG_TICK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function longint mag(input longint v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [CFG_TICK_BITS-1:0] at_least_one(input logic [CFG_TICK_BITS-1:0] t);
      return (t == '0) ? CFG_TICK_BITS'(1) : t;
    endfunction

    function void start_door(input door_t pos);
      door_pos = pos;
      door_cnt = at_least_one(door_ticks);
    endfunction

    function void start_wait(input logic [CFG_TICK_BITS-1:0] t);
      seq_cnt = at_least_one(t);
      seq_run = 1'b1;
    endfunction

    function void note_tick(input ebs_in_t t);
      longint   cx, cy, cz, vz, rx, ry, rz, adx, ady, adz, h, half, rad;
      floor_t   fl;
      bit       moving, in_car, near, cmd;
      ebs_out_t o;
      cx = $signed(t.car_x);
      cy = $signed(t.car_y);
      cz = $signed(t.car_z);
      vz = $signed(t.car_speed_z);
      rx = $signed(t.robot_x);
      ry = $signed(t.robot_y);
      rz = $signed(t.robot_z);
      h = floor_h;
      half = half_w;
      rad = radius;
      adx = mag(rx - cx);
      ady = mag(ry - cy);
      adz = mag(rz - cz);
      if (2 * cz < h) begin
        fl = FLOOR_LOWER;
      end else if (2 * cz > 3 * h) begin
        fl = FLOOR_UPPER;
      end else begin
        fl = FLOOR_BETWEEN;
      end
      moving = mag(vz) > longint'(speed_thr);
      in_car = adx < half && ady < half && adz < longint'(INSIDE_HEIGHT_MM);
      near = 1'b0;
      if (fl == FLOOR_LOWER && !in_car && adx < rad && ady < rad) begin
        near = adx * adx + ady * ady < rad * rad;
      end
      cmd = 1'b0;

      if (door_cnt != '0) begin
        door_cnt--;
        if (door_cnt == '0) begin
          if (door_pos == DOOR_GOING_OPEN) begin
            door_pos = DOOR_OPENED;
          end else if (door_pos == DOOR_GOING_SHUT) begin
            door_pos = DOOR_CLOSED;
          end
        end
      end

      if (seq_run) begin
        if (seq_cnt > 1) begin
          seq_cnt--;
        end else begin
          seq_cnt = '0;
          seq_run = 1'b0;
          if (ph == PH_BOARDING) begin
            start_door(DOOR_GOING_SHUT);
            ph = PH_CLOSING;
          end else if (ph == PH_ARRIVED) begin
            ph = PH_IDLE;
          end
        end
      end

      case (ph)
        PH_IDLE: begin
          if (near && fl == FLOOR_LOWER) begin
            start_door(DOOR_GOING_OPEN);
            ph = PH_OPENING;
          end
        end
        PH_OPENING: begin
          if (door_pos == DOOR_OPENED) begin
            ph = PH_BOARDING;
            start_wait(board_ticks);
          end
        end
        PH_BOARDING: begin
          if (in_car) begin
            start_door(DOOR_GOING_SHUT);
            ph = PH_CLOSING;
            seq_run = 1'b0;
            seq_cnt = '0;
          end
        end
        PH_CLOSING: begin
          if (door_pos == DOOR_CLOSED) begin
            cmd = 1'b1;
            ph = PH_TRAVEL;
          end
        end
        PH_TRAVEL: begin
          if (!moving && fl == FLOOR_UPPER) begin
            start_door(DOOR_GOING_OPEN);
            ph = PH_ARRIVED;
          end
        end
        PH_ARRIVED: begin
          if (!in_car && door_pos == DOOR_OPENED) begin
            start_door(DOOR_GOING_SHUT);
            start_wait(return_ticks);
          end
        end
        default: ph = PH_IDLE;
      endcase

      o.floor_code           = fl;
      o.door_status          = door_pos;
      o.car_moving           = moving;
      o.robot_in_car         = in_car;
      o.sequence_phase       = ph;
      o.floor_command_valid  = cmd;
      o.floor_command_target = cmd;
      due.push_back(o);
    endfunction

    function string show(input ebs_out_t w);
      return $sformatf("floor=%0d door=%0d moving=%0d in_car=%0d phase=%0d cmd=%0d/%0d",
                       w.floor_code, w.door_status, w.car_moving, w.robot_in_car,
                       w.sequence_phase, w.floor_command_valid, w.floor_command_target);
    endfunction

    function void check_word(input ebs_out_t got);
      ebs_out_t want;
      bit       bad;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result word: %s", show(got));
        end
        return;
      end
      want = due.pop_front();
      bad = (got.floor_code !== want.floor_code) ||
            (got.door_status !== want.door_status) ||
            (got.car_moving !== want.car_moving) ||
            (got.robot_in_car !== want.robot_in_car) ||
            (got.sequence_phase !== want.sequence_phase) ||
            (got.floor_command_valid !== want.floor_command_valid) ||
            (got.floor_command_target !== want.floor_command_target);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at cycle %0d", cycles);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  ebs_scoreboard sb;

  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic longint sgn(input longint v);
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] to_coord(input longint v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  function automatic ebs_in_t mk(input int cx, input int cy, input int cz, input int vz,
                                 input int rx, input int ry, input int rz);
    ebs_in_t t;
    t.car_x       = COORD_BITS'(cx);
    t.car_y       = COORD_BITS'(cy);
    t.car_z       = COORD_BITS'(cz);
    t.car_speed_z = COORD_BITS'(vz);
    t.robot_x     = COORD_BITS'(rx);
    t.robot_y     = COORD_BITS'(ry);
    t.robot_z     = COORD_BITS'(rz);
    return t;
  endfunction

  function automatic ebs_in_t noise_tick(input bit corner);
    logic [COORD_BITS-1:0] f [7];
    for (int i = 0; i < 7; i++) begin
      if (!corner) begin
        f[i] = COORD_BITS'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: f[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
          1: f[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
          2: f[i] = '0;
          3: f[i] = '1;
          default: f[i] = COORD_BITS'($urandom);
        endcase
      end
    end
    return {f[0], f[1], f[2], f[3], f[4], f[5], f[6]};
  endfunction

  function automatic ebs_in_t shape_tick(input floor_t fl, input bit moving,
                                         input robot_spot_t spot);
    ebs_in_t t;
    longint  h, half, rad, thr, cx, cy, cz, vz, a, b, dx, dy, dz;
    h = sb.floor_h;
    half = sb.half_w;
    rad = sb.radius;
    thr = sb.speed_thr;
    cx = pick(-12000, 12000);
    cy = pick(-12000, 12000);
    case (fl)
      FLOOR_LOWER: cz = h / 2 - 1 - pick(0, h / 4);
      FLOOR_UPPER: cz = (3 * h) / 2 + 1 + pick(0, 1500);
      default:     cz = h / 2 + 1 + pick(0, h - 2);
    endcase
    vz = moving ? sgn(thr + 1 + pick(0, 3000)) : sgn(pick(0, thr));
    case (spot)
      ROBOT_ABOARD: begin
        dx = sgn(pick(0, (half > 0) ? half - 1 : 0));
        dy = sgn(pick(0, (half > 0) ? half - 1 : 0));
        dz = sgn(pick(0, 999));
      end
      ROBOT_NEAR: begin
        a = pick(0, rad * 7 / 10);
        b = pick(0, rad * 7 / 10);
        dx = sgn(a);
        dy = sgn(b);
        dz = (a < half && b < half) ? sgn(1000 + pick(0, 800)) : sgn(pick(0, 1500));
      end
      default: begin
        dx = sgn(rad + half + 1 + pick(0, 3000));
        dy = sgn(pick(0, 3000));
        dz = sgn(pick(0, 1500));
      end
    endcase
    t.car_x       = to_coord(cx);
    t.car_y       = to_coord(cy);
    t.car_z       = to_coord(cz);
    t.car_speed_z = to_coord(vz);
    t.robot_x     = to_coord(cx + dx);
    t.robot_y     = to_coord(cy + dy);
    t.robot_z     = to_coord(cz + dz);
    return t;
  endfunction

  // Steer toward the next step of the predicted sequence, with some noise.
  function automatic ebs_in_t next_tick();
    int          roll, coin;
    floor_t      fl;
    bit          mov;
    robot_spot_t spot;
    roll = $urandom_range(0, 99);
    coin = $urandom_range(0, 99);
    if (roll < 8) return noise_tick(1'b0);
    if (roll < 12) return noise_tick(1'b1);
    fl = FLOOR_LOWER;
    mov = 1'b0;
    spot = ROBOT_NEAR;
    case (sb.ph) inside
      PH_IDLE, PH_OPENING: begin
        if (coin >= 70) spot = ROBOT_AWAY;
      end
      PH_BOARDING: begin
        if (coin < 25) spot = ROBOT_ABOARD;
      end
      PH_CLOSING: begin
        spot = ROBOT_ABOARD;
      end
      PH_TRAVEL: begin
        spot = ROBOT_ABOARD;
        if (coin < 65) begin
          fl = FLOOR_BETWEEN;
          mov = 1'b1;
        end else if (coin < 75) begin
          fl = FLOOR_UPPER;
          mov = 1'b1;
        end else begin
          fl = FLOOR_UPPER;
        end
      end
      default: begin
        fl = FLOOR_UPPER;
        spot = (coin < 40) ? ROBOT_ABOARD : ROBOT_AWAY;
      end
    endcase
    return shape_tick(fl, mov, spot);
  endfunction

  function automatic void choose_settings(input int p, output logic [CFG_WIDE_BITS-1:0] v [8]);
    logic [CFG_WIDE_BITS-1:0] junk;
    junk = CFG_WIDE_BITS'($urandom_range(0, 63)) << CFG_TICK_BITS;
    case (p)
      1: begin
        v[REG_LEVEL_HEIGHT]    = CFG_WIDE_BITS'(100);
        v[REG_INSIDE_HALF]     = '0;
        v[REG_APPROACH_RADIUS] = '0;
        v[REG_SPEED_THRESHOLD] = '0;
        v[REG_DOOR_TICKS]      = CFG_WIDE_BITS'(1);
        v[REG_BOARDING_TICKS]  = CFG_WIDE_BITS'(1);
        v[REG_RETURN_TICKS]    = CFG_WIDE_BITS'(1);
      end
      2: begin
        v[REG_LEVEL_HEIGHT]    = CFG_WIDE_BITS'(16000);
        v[REG_INSIDE_HALF]     = CFG_WIDE_BITS'(16000);
        v[REG_APPROACH_RADIUS] = CFG_WIDE_BITS'(16000);
        v[REG_SPEED_THRESHOLD] = CFG_WIDE_BITS'(16000);
        v[REG_DOOR_TICKS]      = CFG_WIDE_BITS'(255);
        v[REG_BOARDING_TICKS]  = CFG_WIDE_BITS'(255);
        v[REG_RETURN_TICKS]    = CFG_WIDE_BITS'(255);
      end
      default: begin
        v[REG_LEVEL_HEIGHT]    = CFG_WIDE_BITS'($urandom_range(1000, 8000));
        v[REG_INSIDE_HALF]     = CFG_WIDE_BITS'($urandom_range(300, 2500));
        v[REG_APPROACH_RADIUS] = CFG_WIDE_BITS'($urandom_range(300, 6000));
        v[REG_SPEED_THRESHOLD] = CFG_WIDE_BITS'($urandom_range(0, 400));
        if (p == 3) begin
          // zero tick counts, upper data bits set
          v[REG_DOOR_TICKS]     = junk;
          v[REG_BOARDING_TICKS] = CFG_WIDE_BITS'($urandom_range(0, 63)) << CFG_TICK_BITS;
          v[REG_RETURN_TICKS]   = CFG_WIDE_BITS'($urandom_range(0, 63)) << CFG_TICK_BITS;
        end else begin
          v[REG_DOOR_TICKS]     = CFG_WIDE_BITS'($urandom_range(1, 8));
          v[REG_BOARDING_TICKS] = CFG_WIDE_BITS'($urandom_range(1, 8));
          v[REG_RETURN_TICKS]   = CFG_WIDE_BITS'($urandom_range(1, 8));
          if (p % 2 == 1) begin
            v[REG_DOOR_TICKS]     = v[REG_DOOR_TICKS] | junk;
            v[REG_BOARDING_TICKS] = v[REG_BOARDING_TICKS] | junk;
            v[REG_RETURN_TICKS]   = v[REG_RETURN_TICKS] | junk;
          end
        end
      end
    endcase
    v[REG_UNUSED] = CFG_WIDE_BITS'($urandom);
  endfunction

  task automatic write_regs(input logic [CFG_WIDE_BITS-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_INDEX_BITS'(i);
      wr_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_INDEX_BITS'(i), vals[i]);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_tick(input ebs_in_t t);
    item <= t;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_tick(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_tick(mk(0, 0, 1537, 50, 0, 0, 0));
    send_tick(mk(0, 0, 1538, 51, 0, 0, 1538));
    send_tick(mk(0, 0, 4612, -50, 0, 0, 4612));
    send_tick(mk(0, 0, 4613, -51, 0, 0, 4613));
    send_tick(mk(100, 200, 0, 0, 1224, -924, 999));
    send_tick(mk(100, 200, 0, 0, 1225, 200, 0));
    send_tick(mk(100, 200, 0, 0, 100, 200, 1000));
    send_tick(mk(100, 200, 0, 0, 100, 200, -999));
    send_tick(mk(0, 0, 0, 0, 1200, 1600, 0));
    send_tick(mk(0, 0, 0, 0, 1200, 1599, 0));
    send_tick(mk(0, 0, 0, 0, 2000, 0, 0));
    send_tick(mk(0, 0, 0, 0, -1999, 0, 0));
    send_tick(mk(-32768, 0, 0, 0, 32767, 0, 0));
    send_tick(mk(32767, -32768, 0, 0, -32768, 32767, 0));
  endtask

  task automatic run_random(input int n);
    int burst;
    burst = $urandom_range(1, 40);
    for (int k = 0; k < n; k++) begin
      send_tick(next_tick());
      burst--;
      if (burst == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    logic [CFG_WIDE_BITS-1:0] vals [8];
    rst      <= 1'b1;
    push     <= 1'b0;
    item     <= '0;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p > 0) begin
        wait_drained();
        choose_settings(p, vals);
        write_regs(vals);
      end
      if (p == 0) begin
        run_directed();
        run_random(120);
      end else begin
        run_random((p == 1) ? 50 : (p == 2) ? 200 : 160);
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** elevator_boarding_sequencer: PASSED **");
    end else begin
      $display("** elevator_boarding_sequencer: FAILED **");
    end
    $finish;
  end

  initial begin : result_side
    rx_mode_t rx_mode;
    int       rx_left;
    rx_mode = RX_STREAM;
    rx_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_word(result);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(2, 30) : $urandom_range(10, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_RANDOM: pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= (rx_left % 4 == 0);
        default:   pop <= 1'b0;
      endcase
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("** elevator_boarding_sequencer: FAILED **");
    $finish;
  end

endmodule
